[rtl/bpc_pkg.sv]
package bpc_pkg;

  // Configuration register indexes
  localparam logic [2:0] RegAc1Ac2 = 3'd0;
  localparam logic [2:0] RegAc3Ac4 = 3'd1;
  localparam logic [2:0] RegAc5Ac6 = 3'd2;
  localparam logic [2:0] RegB1B2   = 3'd3;
  localparam logic [2:0] RegMcMd   = 3'd4;
  localparam logic [2:0] RegOss    = 3'd5;

  // Divider geometry
  localparam int TempNumW  = 27;
  localparam int TempDenW  = 20;
  localparam int PressNumW = 32;
  localparam int PressDenW = 17;

  // Compensation constants
  localparam int B6Offset    = 4000;
  localparam int PressScale  = 50000;
  localparam int PolyA       = 3038;
  localparam int PolyB       = -7357;
  localparam int PolyC       = 3791;
  localparam int X3Offset    = 32768;
  localparam int PressMax    = 262143;

  typedef struct packed {
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic        [15:0] ac4;
    logic        [15:0] ac5;
    logic        [15:0] ac6;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic signed [15:0] mc;
    logic signed [15:0] md;
    logic        [1:0]  oss;
  } coef_t;

  typedef struct packed {
    logic signed [18:0] x1;
    logic        [23:0] up;
    logic               tzero;
    logic               neg;
  } tdiv_side_t;

  typedef struct packed {
    logic signed [28:0] b5;
    logic signed [15:0] t;
    logic        [23:0] up;
    logic               tzero;
  } front_item_t;

  typedef struct packed {
    logic signed [15:0] t;
    logic               tzero;
    logic               bzero;
    logic               top;
  } pdiv_side_t;

endpackage

[rtl/bpc_div.sv]
module bpc_div #(
  parameter int NumW  = 32,
  parameter int DenW  = 17,
  parameter int SideW = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  logic [NumW-1:0]  num,
  input  logic [DenW-1:0]  den,
  input  logic [SideW-1:0] side,
  output logic             out_vld,
  output logic [NumW-1:0]  quot,
  output logic [SideW-1:0] out_side
);

  logic             vld_r  [1:NumW];
  logic [DenW-1:0]  rem_r  [1:NumW];
  logic [DenW-1:0]  den_r  [1:NumW];
  logic [NumW-1:0]  num_r  [1:NumW];
  logic [NumW-1:0]  quo_r  [1:NumW];
  logic [SideW-1:0] side_r [1:NumW];

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic             c_vld;
    logic [DenW-1:0]  c_rem;
    logic [DenW-1:0]  c_den;
    logic [NumW-1:0]  c_num;
    logic [NumW-1:0]  c_quo;
    logic [SideW-1:0] c_side;
    logic [DenW:0]    trial;
    logic [DenW:0]    diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign c_vld  = in_vld;
      assign c_rem  = '0;
      assign c_den  = den;
      assign c_num  = num;
      assign c_quo  = '0;
      assign c_side = side;
    end else begin : g_next
      assign c_vld  = vld_r[k];
      assign c_rem  = rem_r[k];
      assign c_den  = den_r[k];
      assign c_num  = num_r[k];
      assign c_quo  = quo_r[k];
      assign c_side = side_r[k];
    end

    assign trial = {c_rem, c_num[NumW-1-k]};
    assign diff  = trial - {1'b0, c_den};
    assign ge    = !diff[DenW];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= c_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
        den_r[k+1]  <= c_den;
        num_r[k+1]  <= c_num;
        quo_r[k+1]  <= {c_quo[NumW-2:0], ge};
        side_r[k+1] <= c_side;
      end
    end
  end

  assign out_vld  = vld_r[NumW];
  assign quot     = quo_r[NumW];
  assign out_side = side_r[NumW];

endmodule

[rtl/bpc_front.sv]
module bpc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  bpc_pkg::coef_t        coef,
  input  logic                  in_vld,
  input  logic [15:0]           raw_temperature,
  input  logic [23:0]           raw_pressure_word,
  output logic                  out_vld,
  output bpc_pkg::front_item_t  out_item
);

  logic               s1_vld;
  logic signed [16:0] s1_d;
  logic [23:0]        s1_up;
  logic               s2_vld;
  logic signed [33:0] s2_prod;
  logic [23:0]        s2_up;
  logic               s3_vld;
  logic signed [18:0] s3_x1;
  logic signed [19:0] s3_den;
  logic signed [26:0] s3_num;
  logic [23:0]        s3_up;
  logic               s5_vld;
  logic signed [28:0] s5_b5;
  logic [23:0]        s5_up;
  logic               s5_tzero;

  logic [23:0]                  up_c;
  logic signed [18:0]           x1_c;
  logic signed [19:0]           den_c;
  logic [bpc_pkg::TempDenW-1:0] den_mag;
  logic [bpc_pkg::TempNumW-1:0] num_mag;
  bpc_pkg::tdiv_side_t          dside;
  bpc_pkg::tdiv_side_t          qside;
  logic                         q_vld;
  logic [bpc_pkg::TempNumW-1:0] quot;
  logic signed [27:0]           x2_c;
  logic signed [29:0]           t_round;
  logic signed [25:0]           t_wide;
  logic signed [15:0]           t_sat;

  always_comb begin
    up_c    = raw_pressure_word >> (4'd8 - {2'b00, coef.oss});
    x1_c    = $signed(s2_prod[33:15]);
    den_c   = 20'(x1_c) + 20'(coef.md);
    den_mag = s3_den[19] ? 20'(-s3_den) : 20'(s3_den);
    num_mag = s3_num[26] ? 27'(-s3_num) : 27'(s3_num);
    dside.x1    = s3_x1;
    dside.up    = s3_up;
    dside.tzero = (s3_den == 20'sd0);
    dside.neg   = s3_den[19] ^ s3_num[26];
    x2_c    = qside.neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    t_round = 30'(s5_b5) + 30'sd8;
    t_wide  = $signed(t_round[29:4]);
    if (t_wide > 26'sd32767) begin
      t_sat = 16'sh7fff;
    end else if (t_wide < -26'sd32768) begin
      t_sat = -16'sh8000;
    end else begin
      t_sat = t_wide[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      s2_vld  <= 1'b0;
      s3_vld  <= 1'b0;
      s5_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      s1_vld  <= in_vld;
      s2_vld  <= s1_vld;
      s3_vld  <= s2_vld;
      s5_vld  <= q_vld;
      out_vld <= s5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d     <= 17'({1'b0, raw_temperature}) - 17'({1'b0, coef.ac6});
      s1_up    <= up_c;
      s2_prod  <= 34'(s1_d) * 34'($signed({1'b0, coef.ac5}));
      s2_up    <= s1_up;
      s3_x1    <= x1_c;
      s3_den   <= den_c;
      s3_num   <= $signed({coef.mc, 11'b0});
      s3_up    <= s2_up;
      s5_b5    <= 29'(qside.x1) + 29'(x2_c);
      s5_up    <= qside.up;
      s5_tzero <= qside.tzero;
      out_item.b5    <= s5_b5;
      out_item.t     <= s5_tzero ? 16'sd0 : t_sat;
      out_item.up    <= s5_up;
      out_item.tzero <= s5_tzero;
    end
  end

  bpc_div #(
    .NumW  (bpc_pkg::TempNumW),
    .DenW  (bpc_pkg::TempDenW),
    .SideW ($bits(bpc_pkg::tdiv_side_t))
  ) u_tdiv (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s3_vld),
    .num      (num_mag),
    .den      (den_mag),
    .side     (dside),
    .out_vld  (q_vld),
    .quot     (quot),
    .out_side (qside)
  );

endmodule

[rtl/bpc_back.sv]
module bpc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  bpc_pkg::coef_t        coef,
  input  logic                  in_vld,
  input  bpc_pkg::front_item_t  in_item,
  output logic                  out_vld,
  output logic signed [15:0]    temperature_tenths,
  output logic [17:0]           pressure_pa,
  output logic                  status
);

  typedef struct packed {
    logic signed [15:0] t;
    logic [23:0]        up;
    logic               tzero;
  } carry_t;

  logic               b1_vld, b2_vld, b3_vld, b4_vld, b5_vld;
  carry_t             b1_c, b2_c, b3_c, b4_c, b5_c;
  logic signed [29:0] b1_b6;
  logic signed [59:0] b2_sq;
  logic signed [45:0] b2_a2, b2_a3;
  logic signed [63:0] b3_b2q, b3_b1q;
  logic signed [45:0] b3_a2, b3_a3;
  logic [31:0]        b4_b3, b4_w;
  logic [16:0]        b5_b4;
  logic [31:0]        b5_b7;

  logic               b6_vld, b7_vld, b8_vld;
  bpc_pkg::pdiv_side_t b6_s, b7_s, b8_s;
  logic [32:0]        b6_p, b7_p, b8_p;
  logic [49:0]        b7_sq;
  logic signed [47:0] b7_m;
  logic [45:0]        b8_x1;
  logic signed [31:0] b8_x2;

  logic signed [47:0] q_c;
  logic signed [63:0] x3a_c, v_c, x3b_c;
  logic [31:0]        w_c;
  logic [47:0]        b4p_c;
  logic [31:0]        diff_c;
  logic [15:0]        scale_c;
  logic [47:0]        b7p_c;
  bpc_pkg::pdiv_side_t dside, qside;
  logic [31:0]        dnum;
  logic               q_vld;
  logic [31:0]        quot;
  logic [61:0]        x1p_c;
  logic signed [47:0] s_c;
  logic signed [48:0] pf_c;
  logic [17:0]        p_sat;

  always_comb begin
    q_c    = $signed(b2_sq[59:12]);
    x3a_c  = (b3_b2q >>> 11) + 64'(b3_a2 >>> 11);
    v_c    = ((64'(coef.ac1) <<< 2) + x3a_c) <<< coef.oss;
    v_c    = v_c + 64'sd2;
    x3b_c  = (64'(b3_a3 >>> 13) + (b3_b1q >>> 16) + 64'sd2) >>> 2;
    w_c    = x3b_c[31:0] + 32'(bpc_pkg::X3Offset);
    b4p_c  = 48'(coef.ac4) * 48'(b4_w);
    diff_c = {8'b0, b4_c.up} - b4_b3;
    scale_c = 16'(bpc_pkg::PressScale) >> coef.oss;
    b7p_c  = 48'(diff_c) * 48'(scale_c);
    dside.t     = b5_c.t;
    dside.tzero = b5_c.tzero;
    dside.bzero = (b5_b4 == 17'd0);
    dside.top   = b5_b7[31];
    // Double first where it cannot overflow, else double the quotient later
    dnum  = b5_b7[31] ? b5_b7 : {b5_b7[30:0], 1'b0};
    x1p_c = 62'(b7_sq) * 62'(bpc_pkg::PolyA);
    s_c   = 48'($signed({2'b00, b8_x1})) + 48'(b8_x2) + 48'(bpc_pkg::PolyC);
    pf_c  = $signed({16'b0, b8_p}) + 49'(s_c >>> 4);
    if (pf_c < 49'sd0) begin
      p_sat = 18'd0;
    end else if (pf_c > 49'(bpc_pkg::PressMax)) begin
      p_sat = 18'(bpc_pkg::PressMax);
    end else begin
      p_sat = pf_c[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_vld  <= 1'b0;
      b2_vld  <= 1'b0;
      b3_vld  <= 1'b0;
      b4_vld  <= 1'b0;
      b5_vld  <= 1'b0;
      b6_vld  <= 1'b0;
      b7_vld  <= 1'b0;
      b8_vld  <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      b1_vld  <= in_vld;
      b2_vld  <= b1_vld;
      b3_vld  <= b2_vld;
      b4_vld  <= b3_vld;
      b5_vld  <= b4_vld;
      b6_vld  <= q_vld;
      b7_vld  <= b6_vld;
      b8_vld  <= b7_vld;
      out_vld <= b8_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_c   <= '{t: in_item.t, up: in_item.up, tzero: in_item.tzero};
      b1_b6  <= 30'(in_item.b5) - 30'(bpc_pkg::B6Offset);
      b2_c   <= b1_c;
      b2_sq  <= 60'(b1_b6) * 60'(b1_b6);
      b2_a2  <= 46'(coef.ac2) * 46'(b1_b6);
      b2_a3  <= 46'(coef.ac3) * 46'(b1_b6);
      b3_c   <= b2_c;
      b3_b2q <= 64'(coef.b2) * 64'(q_c);
      b3_b1q <= 64'(coef.b1) * 64'(q_c);
      b3_a2  <= b2_a2;
      b3_a3  <= b2_a3;
      b4_c   <= b3_c;
      b4_b3  <= v_c[33:2];
      b4_w   <= w_c;
      b5_c   <= b4_c;
      b5_b4  <= b4p_c[31:15];
      b5_b7  <= b7p_c[31:0];
      b6_s   <= qside;
      b6_p   <= qside.top ? {quot, 1'b0} : {1'b0, quot};
      b7_s   <= b6_s;
      b7_p   <= b6_p;
      b7_sq  <= 50'(b6_p[32:8]) * 50'(b6_p[32:8]);
      b7_m   <= 48'(bpc_pkg::PolyB) * $signed({15'b0, b6_p});
      b8_s   <= b7_s;
      b8_p   <= b7_p;
      b8_x1  <= x1p_c[61:16];
      b8_x2  <= $signed(b7_m[47:16]);
      temperature_tenths <= b8_s.t;
      if (b8_s.tzero || b8_s.bzero) begin
        pressure_pa <= 18'd0;
        status      <= 1'b1;
      end else begin
        pressure_pa <= p_sat;
        status      <= 1'b0;
      end
    end
  end

  bpc_div #(
    .NumW  (bpc_pkg::PressNumW),
    .DenW  (bpc_pkg::PressDenW),
    .SideW ($bits(bpc_pkg::pdiv_side_t))
  ) u_pdiv (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (b5_vld),
    .num      (dnum),
    .den      (b5_b4),
    .side     (dside),
    .out_vld  (q_vld),
    .quot     (quot),
    .out_side (qside)
  );

endmodule

[rtl/barometric_pressure_compensation_unit.sv]
// Barometer temperature and pressure compensation.
// Input channel: in_valid / in_stall with raw_temperature and
// raw_pressure_word; an item is taken when in_valid is high and in_stall low.
// Output channel: out_valid / out_stall with temperature_tenths (signed
// tenths of a degree), pressure_pa (saturated pascals) and status (1 when a
// compensation divisor was zero; pressure then reads 0, and temperature too
// if the temperature divisor was zero).
// Calibration and oversampling are loaded through cfg_we / cfg_index /
// cfg_data; the user must load them only while no item is in flight, as
// the block does not enforce it. Indexes above five are dropped. Throughput:
// one item per clock unless out_stall holds a valid result. The pipeline is
// the two one-bit-per-stage dividers (27 and 32 stages) plus multiply stages.
// When out_stall holds a valid result, the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is lost or repeated.
// Synchronous reset empties the pipeline and clears all calibration to zero.
module barometric_pressure_compensation_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        raw_temperature,
  input  logic [23:0]        raw_pressure_word,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] temperature_tenths,
  output logic [17:0]        pressure_pa,
  output logic               status,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [31:0] coef_ac1_ac2, coef_ac3_ac4, coef_ac5_ac6, coef_b1_b2, coef_mc_md;
  logic [1:0]  oversampling;
  bpc_pkg::coef_t       coef;
  bpc_pkg::front_item_t mid_item;
  logic                 mid_vld;
  logic                 en;

  // Advance everything unless a finished result is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_ac1_ac2 <= '0;
      coef_ac3_ac4 <= '0;
      coef_ac5_ac6 <= '0;
      coef_b1_b2   <= '0;
      coef_mc_md   <= '0;
      oversampling <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpc_pkg::RegAc1Ac2: coef_ac1_ac2 <= cfg_data;
        bpc_pkg::RegAc3Ac4: coef_ac3_ac4 <= cfg_data;
        bpc_pkg::RegAc5Ac6: coef_ac5_ac6 <= cfg_data;
        bpc_pkg::RegB1B2:   coef_b1_b2   <= cfg_data;
        bpc_pkg::RegMcMd:   coef_mc_md   <= cfg_data;
        bpc_pkg::RegOss:    oversampling <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    coef.ac1 = $signed(coef_ac1_ac2[31:16]);
    coef.ac2 = $signed(coef_ac1_ac2[15:0]);
    coef.ac3 = $signed(coef_ac3_ac4[31:16]);
    coef.ac4 = coef_ac3_ac4[15:0];
    coef.ac5 = coef_ac5_ac6[31:16];
    coef.ac6 = coef_ac5_ac6[15:0];
    coef.b1  = $signed(coef_b1_b2[31:16]);
    coef.b2  = $signed(coef_b1_b2[15:0]);
    coef.mc  = $signed(coef_mc_md[31:16]);
    coef.md  = $signed(coef_mc_md[15:0]);
    coef.oss = oversampling;
  end

  bpc_front u_front (
    .clk               (clk),
    .rst               (rst),
    .en                (en),
    .coef              (coef),
    .in_vld            (in_valid),
    .raw_temperature   (raw_temperature),
    .raw_pressure_word (raw_pressure_word),
    .out_vld           (mid_vld),
    .out_item          (mid_item)
  );

  bpc_back u_back (
    .clk                (clk),
    .rst                (rst),
    .en                 (en),
    .coef               (coef),
    .in_vld             (mid_vld),
    .in_item            (mid_item),
    .out_vld            (out_valid),
    .temperature_tenths (temperature_tenths),
    .pressure_pa        (pressure_pa),
    .status             (status)
  );

endmodule

[rtl/bpc_checker.sv]
module bpc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] temperature_tenths,
  input logic [17:0]        pressure_pa,
  input logic               status
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while a result is held");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled with the output free");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(temperature_tenths)
      && $stable(pressure_pa) && $stable(status))
    else $error("held result changed");

endmodule

bind barometric_pressure_compensation_unit bpc_checker u_bpc_checker (
  .clk                (clk),
  .rst                (rst),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .temperature_tenths (temperature_tenths),
  .pressure_pa        (pressure_pa),
  .status             (status)
);

[verif/barometric_pressure_compensation_unit_test.sv]
`timescale 1ns / 100ps

module barometric_pressure_compensation_unit_test;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [15:0] raw_temperature;
  logic [23:0] raw_pressure_word;
  logic out_valid;
  logic out_stall;
  logic signed [15:0] temperature_tenths;
  logic [17:0] pressure_pa;
  logic status;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  typedef struct packed {
    logic signed [15:0] temp;
    logic [17:0] press;
    logic err;
  } reading_t;

  reading_t pending_readings[$];
  bpc_pkg::coef_t cal;
  int mismatches;
  int idle_cycles;
  int stall_left;
  bit timed_out;
  bit stall_free;

  barometric_pressure_compensation_unit dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .raw_temperature(raw_temperature), .raw_pressure_word(raw_pressure_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .temperature_tenths(temperature_tenths), .pressure_pa(pressure_pa),
    .status(status), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Flooring shift on a 64-bit signed value.
  function automatic longint fshr(longint x, int n);
    return x >>> n;
  endfunction

  function automatic reading_t compensate(logic [15:0] ut_w, logic [23:0] up_w);
    reading_t r;
    longint ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md, ut;
    longint x1, x2, x3, b5, b6, b3, t, p, den;
    int unsigned oss, up, b4, b7, ac4;
    ac1 = longint'(cal.ac1); ac2 = longint'(cal.ac2); ac3 = longint'(cal.ac3);
    ac4 = 32'(cal.ac4);
    ac5 = longint'(cal.ac5); ac6 = longint'(cal.ac6);
    b1 = longint'(cal.b1); b2 = longint'(cal.b2);
    mc = longint'(cal.mc); md = longint'(cal.md); oss = 32'(cal.oss);
    ut = longint'(ut_w);
    up = 32'(up_w) >> (32'd8 - oss);
    r = '0;
    x1 = fshr((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) begin
      r.err = 1'b1;
      return r;
    end
    x2 = (mc * 2048) / den;
    b5 = x1 + x2;
    t = fshr(b5 + 8, 4);
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    r.temp = t[15:0];
    b6 = b5 - bpc_pkg::B6Offset;
    x1 = fshr(b2 * fshr(b6 * b6, 12), 11);
    x2 = fshr(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = fshr((ac1 * 4 + x3) * (64'sd1 << oss) + 2, 2);
    x1 = fshr(ac3 * b6, 13);
    x2 = fshr(b1 * fshr(b6 * b6, 12), 16);
    x3 = fshr(x1 + x2 + 2, 2);
    b4 = (ac4 * 32'(x3 + bpc_pkg::X3Offset)) >> 15;
    b7 = (up - 32'(b3)) * (32'(bpc_pkg::PressScale) >> oss);
    if (b4 == 0) begin
      r.err = 1'b1;
      return r;
    end
    if (b7 < 32'h8000_0000) p = longint'((b7 * 2) / b4);
    else p = longint'(b7 / b4) * 2;
    x1 = fshr(p, 8) * fshr(p, 8);
    x1 = fshr(x1 * bpc_pkg::PolyA, 16);
    x2 = fshr(bpc_pkg::PolyB * p, 16);
    p = p + fshr(x1 + x2 + bpc_pkg::PolyC, 4);
    if (p < 0) p = 0;
    if (p > bpc_pkg::PressMax) p = longint'(bpc_pkg::PressMax);
    r.press = p[17:0];
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Valid stays high between back-to-back items; drop it only for a gap.
  task automatic send_reading(logic [15:0] ut_w, logic [23:0] up_w, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    cfg_we <= 1'b0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_temperature <= ut_w;
    raw_pressure_word <= up_w;
    pending_readings.push_back(compensate(ut_w, up_w));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    cfg_we <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Write enable stays high across a burst of writes; the next item drops it.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      bpc_pkg::RegAc1Ac2: {cal.ac1, cal.ac2} = val;
      bpc_pkg::RegAc3Ac4: {cal.ac3, cal.ac4} = val;
      bpc_pkg::RegAc5Ac6: {cal.ac5, cal.ac6} = val;
      bpc_pkg::RegB1B2:   {cal.b1, cal.b2} = val;
      bpc_pkg::RegMcMd:   {cal.mc, cal.md} = val;
      bpc_pkg::RegOss:    cal.oss = val[1:0];
      default: ;
    endcase
  endtask

  task automatic load_typical(logic [1:0] oss);
    write_reg(bpc_pkg::RegAc1Ac2, {16'sd408, -16'sd72});
    write_reg(bpc_pkg::RegAc3Ac4, {-16'sd14383, 16'd32741});
    write_reg(bpc_pkg::RegAc5Ac6, {16'd32757, 16'd23153});
    write_reg(bpc_pkg::RegB1B2, {16'sd6190, 16'sd4});
    write_reg(bpc_pkg::RegMcMd, {-16'sd8711, 16'sd2868});
    write_reg(bpc_pkg::RegOss, {30'd0, oss});
  endtask

  task automatic test_directed();
    load_typical(2'd0);
    send_reading(16'd27898, 24'd23843 << 8, 1'b0);
    send_reading(16'd0, 24'd0, 1'b0);
    send_reading(16'hFFFF, 24'hFFFFFF, 1'b0);
    send_reading(16'h5555, 24'hAAAAAA, 1'b1);
    send_reading(16'hAAAA, 24'h555555, 1'b1);
    drain();
    load_typical(2'd3);
    send_reading(16'd27898, 24'hFFFFFF, 1'b0);
    send_reading(16'd0, 24'd0, 1'b0);
    drain();
    // Temperature divisor zero: ac5 = 0 makes x1 = 0, md = 0.
    write_reg(bpc_pkg::RegAc5Ac6, 32'h0000_1234);
    write_reg(bpc_pkg::RegMcMd, 32'h1234_0000);
    send_reading(16'd100, 24'h123456, 1'b0);
    drain();
    // Pressure divisor zero: ac4 = 0.
    write_reg(bpc_pkg::RegMcMd, {-16'sd8711, 16'sd2868});
    write_reg(bpc_pkg::RegAc3Ac4, 32'hC7D1_0000);
    send_reading(16'd30000, 24'h800000, 1'b0);
    drain();
    // Extreme coefficients for saturation.
    write_reg(bpc_pkg::RegAc1Ac2, 32'h7FFF_8000);
    write_reg(bpc_pkg::RegAc3Ac4, 32'h8000_FFFF);
    write_reg(bpc_pkg::RegAc5Ac6, 32'hFFFF_0000);
    write_reg(bpc_pkg::RegB1B2, 32'h8000_7FFF);
    write_reg(bpc_pkg::RegMcMd, 32'h7FFF_0001);
    write_reg(3'd6, 32'hFFFF_FFFF);
    write_reg(3'd7, 32'h0);
    write_reg(bpc_pkg::RegOss, 32'hFFFF_FFFF);
    send_reading(16'hFFFF, 24'hFFFFFF, 1'b0);
    send_reading(16'h0000, 24'h000000, 1'b0);
    send_reading(16'h8000, 24'h800000, 1'b0);
    drain();
  endtask

  task automatic test_random(int n, bit typical);
    int i;
    logic [1:0] oss;
    oss = 2'($urandom_range(0, 3));
    if (typical) load_typical(oss);
    else begin
      write_reg(bpc_pkg::RegAc1Ac2, $urandom());
      write_reg(bpc_pkg::RegAc3Ac4, $urandom());
      write_reg(bpc_pkg::RegAc5Ac6, $urandom());
      write_reg(bpc_pkg::RegB1B2, $urandom());
      write_reg(bpc_pkg::RegMcMd, $urandom());
      write_reg(bpc_pkg::RegOss, {30'd0, oss});
    end
    for (i = 0; i < n; i++) begin
      if (typical && $urandom_range(0, 3) != 0)
        send_reading(16'($urandom_range(20000, 40000)),
                     24'($urandom_range(0, 24'hFFFFFF)), i > n / 2);
      else
        send_reading(16'($urandom()), 24'($urandom()), i > n / 2);
    end
    drain();
  endtask

  // Receiver side: random stalls, compare each item on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_readings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %0d %0d %0d",
            temperature_tenths, pressure_pa, status);
        end else begin
          reading_t e;
          e = pending_readings.pop_front();
          if (e.temp !== temperature_tenths || e.press !== pressure_pa ||
              e.err !== status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp t=%0d p=%0d s=%0d got t=%0d p=%0d s=%0d",
                e.temp, e.press, e.err, temperature_tenths, pressure_pa, status);
          end
        end
      end
      // Mostly short stalls, now and then a long one
      if (stall_free) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        stall_left <= ($urandom_range(0, 31) == 0) ? int'($urandom_range(10, 40)) : 0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Hold-off watchdog: cycles with no item moving on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000 && !timed_out) begin
      timed_out = 1'b1;
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int k;
    rst = 1'b1;
    in_valid = 1'b0;
    raw_temperature = '0;
    raw_pressure_word = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    out_stall = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    stall_left = 0;
    timed_out = 1'b0;
    stall_free = 1'b0;
    cal = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    for (k = 0; k < 8; k++) test_random(100, 1'b1);
    stall_free = 1'b1;
    test_random(100, 1'b1);
    stall_free = 1'b0;
    for (k = 0; k < 2; k++) test_random(50, 1'b0);
    drain();
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
